>>> src/ncp_pkg.sv
// Shared types and constants for the nearest-color palette block.
package ncp_pkg;

  localparam int unsigned ENTRIES_DEF     = 256;
  localparam int unsigned COMP_BITS_DEF   = 15;

  // Fixed widths of the stream fields.
  localparam int unsigned IDX_W           = 8;
  localparam int unsigned FIELD_W         = 15;
  localparam int unsigned COUNT_W         = 9;
  localparam int unsigned S_TDATA_W       = 56;
  localparam int unsigned M_TDATA_W       = 24;

  typedef enum logic [1:0] {
    FUNC_APPEND    = 2'd0,
    FUNC_OVERWRITE = 2'd1,
    FUNC_DELETE    = 2'd2,
    FUNC_MAP       = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAP,
    ST_DEL,
    ST_RESP
  } state_e;

endpackage

>>> src/nearest_color_palette.sv
// Palette of colors with append, overwrite, delete and nearest-color lookup.
//
// The block stores up to ENTRIES colors in one memory with one write port and one
// registered read port, and answers one operation per input beat with one output
// beat. Append and overwrite write the memory as the beat is taken and then show
// the result. A map reads the stored entries one per cycle through a four-stage
// distance unit (read, absolute difference, square, sum and compare); a delete
// moves each later entry down through the same read port, one per cycle. The
// block takes no new beat until the result of the current one has been taken.
// The memory needs no clearing after reset.
module nearest_color_palette #(
  parameter int unsigned ENTRIES        = ncp_pkg::ENTRIES_DEF,
  parameter int unsigned COMPONENT_BITS = ncp_pkg::COMP_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // entry_index[7:0], red[22:8], green[37:23], blue[52:38], zero pad[55:53]
  input  logic [ncp_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // func[1:0]
  input  logic [1:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // result_index[7:0], entry_count[16:8], zero pad[23:17]
  output logic [ncp_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // ok[0]
  output logic                           m_axis_tuser
);
  import ncp_pkg::*;

  localparam int unsigned CB   = COMPONENT_BITS;
  localparam int unsigned AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW   = $clog2(ENTRIES + 1);
  localparam int unsigned CMPW = (CW > IDX_W) ? CW : IDX_W;
  localparam int unsigned EW   = 3 * CB;
  localparam int unsigned SQW  = 2 * CB;
  localparam int unsigned DW   = SQW + 2;

  localparam logic [CW-1:0]   FULL_C    = CW'(ENTRIES);
  localparam logic [CMPW-1:0] ENTRIES_C = CMPW'(ENTRIES);

  // Input beat fields.
  logic [IDX_W-1:0] in_idx;
  logic [EW-1:0]    in_col;
  func_e            in_func;
  logic             s_accept;

  assign in_idx   = s_axis_tdata[IDX_W-1:0];
  assign in_col   = {CB'(s_axis_tdata[IDX_W+2*FIELD_W +: FIELD_W]),
                     CB'(s_axis_tdata[IDX_W+FIELD_W +: FIELD_W]),
                     CB'(s_axis_tdata[IDX_W +: FIELD_W])};
  assign in_func  = func_e'(s_axis_tuser);
  assign s_accept = s_axis_tvalid && s_axis_tready;

  // Control state.
  state_e           state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    rd_cnt_q, rd_cnt_d;
  logic [IDX_W-1:0] res_idx_q, res_idx_d;
  logic             ok_q, ok_d;

  // Memory ports.
  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [EW-1:0]    wr_data;
  logic [EW-1:0]    mem [ENTRIES];
  logic [EW-1:0]    rdata_q;

  // Distance unit pipeline.
  logic             v1_q, v2_q, v3_q;
  logic [AW-1:0]    i1_q, i2_q, i3_q;
  logic [CB-1:0]    query_q [3];
  logic [CB-1:0]    diff_q [3];
  logic [SQW-1:0]   sq_q [3];
  logic [DW-1:0]    dist_sum;
  logic [DW-1:0]    best_q;
  logic [AW-1:0]    best_idx_q;
  logic             have_best_q;

  assign dist_sum = DW'(sq_q[0]) + DW'(sq_q[1]) + DW'(sq_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      rd_cnt_q  <= '0;
      res_idx_q <= '0;
      ok_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rd_cnt_q  <= rd_cnt_d;
      res_idx_q <= res_idx_d;
      ok_q      <= ok_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    rd_cnt_d      = rd_cnt_q;
    res_idx_d     = res_idx_q;
    ok_d          = ok_q;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          res_idx_d = '0;
          ok_d      = 1'b1;
          state_d   = ST_RESP;
          unique case (in_func)
            FUNC_APPEND: begin
              if (count_q != FULL_C) begin
                wr_en     = 1'b1;
                wr_addr   = count_q[AW-1:0];
                wr_data   = in_col;
                res_idx_d = IDX_W'(count_q);
                count_d   = count_q + 1'b1;
              end else begin
                ok_d = 1'b0;
              end
            end
            FUNC_OVERWRITE: begin
              if (CMPW'(in_idx) < ENTRIES_C) begin
                wr_en   = 1'b1;
                wr_addr = AW'(in_idx);
                wr_data = in_col;
              end else begin
                ok_d = 1'b0;
              end
            end
            FUNC_DELETE: begin
              if (CMPW'(in_idx) < CMPW'(count_q)) begin
                rd_cnt_d = CW'(in_idx) + 1'b1;
                state_d  = ST_DEL;
              end else begin
                ok_d = 1'b0;
              end
            end
            FUNC_MAP: begin
              if (count_q != '0) begin
                rd_cnt_d = '0;
                state_d  = ST_MAP;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MAP: begin
        if (rd_cnt_q != count_q) begin
          rd_en    = 1'b1;
          rd_addr  = rd_cnt_q[AW-1:0];
          rd_cnt_d = rd_cnt_q + 1'b1;
        end else if (!v1_q && !v2_q && !v3_q) begin
          res_idx_d = IDX_W'(best_idx_q);
          state_d   = ST_RESP;
        end
      end
      ST_DEL: begin
        if (rd_cnt_q != count_q) begin
          rd_en    = 1'b1;
          rd_addr  = rd_cnt_q[AW-1:0];
          rd_cnt_d = rd_cnt_q + 1'b1;
        end
        // Each entry that the read port returns is written one place lower.
        if (v1_q) begin
          wr_en   = 1'b1;
          wr_addr = i1_q - 1'b1;
          wr_data = rdata_q;
        end
        if (rd_cnt_q == count_q && !v1_q) begin
          count_d = count_q - 1'b1;
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Palette memory.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      have_best_q <= 1'b0;
    end else begin
      v1_q <= rd_en;
      v2_q <= v1_q && (state_q == ST_MAP);
      v3_q <= v2_q;
      if (s_accept) begin
        have_best_q <= 1'b0;
      end else if (v3_q && (!have_best_q || dist_sum < best_q)) begin
        have_best_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i1_q <= rd_addr;
    i2_q <= i1_q;
    i3_q <= i2_q;
    if (s_accept) begin
      for (int k = 0; k < 3; k++) begin
        query_q[k] <= in_col[k*CB +: CB];
      end
      best_idx_q <= '0;
    end else if (v3_q && (!have_best_q || dist_sum < best_q)) begin
      // Only a strictly smaller distance wins, so the first minimum stays.
      best_q     <= dist_sum;
      best_idx_q <= i3_q;
    end
    for (int k = 0; k < 3; k++) begin
      diff_q[k] <= (rdata_q[k*CB +: CB] >= query_q[k]) ?
                   rdata_q[k*CB +: CB] - query_q[k] :
                   query_q[k] - rdata_q[k*CB +: CB];
      sq_q[k]   <= SQW'(diff_q[k]) * SQW'(diff_q[k]);
    end
  end

  assign m_axis_tdata = {(M_TDATA_W - IDX_W - COUNT_W)'(0), COUNT_W'(count_q), res_idx_q};
  assign m_axis_tuser = ok_q;

endmodule

>>> sim/nearest_color_palette_checker.sv
// Scoreboard for the nearest-color palette: predicts each result beat and compares it.
module nearest_color_palette_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [ncp_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  logic [1:0]                    s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [ncp_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input  logic                          m_axis_tuser,
  output int unsigned                   mismatch_count_o,
  output int unsigned                   pending_o
);
  import ncp_pkg::*;

  typedef struct packed {
    logic [FIELD_W-1:0] blue;
    logic [FIELD_W-1:0] green;
    logic [FIELD_W-1:0] red;
  } color_t;

  typedef struct packed {
    logic [IDX_W-1:0]   slot;
    logic               ok;
    logic [COUNT_W-1:0] count;
  } palette_result_t;

  color_t          palette [ENTRIES_DEF];
  int unsigned     entry_total;
  palette_result_t expected_q [$];
  palette_result_t want;
  int unsigned     mismatches;

  assign mismatch_count_o = mismatches;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] %s", $time, msg);
  endtask

  function automatic longint unsigned color_distance(input color_t a, input color_t b);
    longint unsigned dr, dg, db;
    dr = (a.red >= b.red) ? a.red - b.red : b.red - a.red;
    dg = (a.green >= b.green) ? a.green - b.green : b.green - a.green;
    db = (a.blue >= b.blue) ? a.blue - b.blue : b.blue - a.blue;
    return dr * dr + dg * dg + db * db;
  endfunction

  // Applies one operation to the palette copy and returns the result it gives.
  function automatic palette_result_t apply_op(input func_e op, input logic [IDX_W-1:0] slot,
                                               input color_t col);
    palette_result_t res;
    longint unsigned best, dist_sq;
    int unsigned     k;
    res.slot = '0;
    res.ok   = 1'b1;
    case (op)
      FUNC_APPEND: begin
        if (entry_total < ENTRIES_DEF) begin
          palette[entry_total] = col;
          res.slot = entry_total[IDX_W-1:0];
          entry_total++;
        end else begin
          res.ok = 1'b0;
        end
      end
      FUNC_OVERWRITE: begin
        if (slot < ENTRIES_DEF) palette[slot] = col;
        else res.ok = 1'b0;
      end
      FUNC_DELETE: begin
        // An empty palette also lands here, since no index is below zero.
        if (slot >= entry_total) begin
          res.ok = 1'b0;
        end else begin
          for (k = slot; k + 1 < entry_total; k++) palette[k] = palette[k + 1];
          entry_total--;
        end
      end
      default: begin
        best = '1;
        for (k = 0; k < entry_total; k++) begin
          dist_sq = color_distance(palette[k], col);
          // Only a strictly smaller distance wins, so ties keep the lower index.
          if (dist_sq < best) begin
            best     = dist_sq;
            res.slot = k[IDX_W-1:0];
          end
        end
      end
    endcase
    res.count = entry_total[COUNT_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_total = 0;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      // The result side goes first: a result can never belong to a beat taken at the same edge.
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result beat with no operation outstanding: tdata %h ok %b",
                                    m_axis_tdata, m_axis_tuser));
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tdata[7:0] !== want.slot)
            report_mismatch($sformatf("result_index got %0d expected %0d",
                                      m_axis_tdata[7:0], want.slot));
          if (m_axis_tuser !== want.ok)
            report_mismatch($sformatf("ok got %b expected %b", m_axis_tuser, want.ok));
          if (m_axis_tdata[16:8] !== want.count)
            report_mismatch($sformatf("entry_count got %0d expected %0d",
                                      m_axis_tdata[16:8], want.count));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(apply_op(func_e'(s_axis_tuser), s_axis_tdata[7:0],
                                      {s_axis_tdata[52:38], s_axis_tdata[37:23],
                                       s_axis_tdata[22:8]}));
      pending_o <= expected_q.size();
    end
  end

endmodule

>>> sim/nearest_color_palette_tb.sv
// Top of the nearest-color palette testbench: clock, reset, beat traffic and verdict.
module nearest_color_palette_tb;
  import ncp_pkg::*;

  localparam int unsigned SINK_HOLD_CYCLES = 600;
  localparam int unsigned DRAIN_CYCLES     = 300;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [1:0]           s_axis_tuser = FUNC_APPEND;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;

  int unsigned mismatch_count;
  int unsigned pending_results;
  int unsigned src_idle_pct = 10;
  int unsigned sink_idle_pct = 87;
  logic        sink_hold_req = 1'b0;
  int unsigned color_mode = 0;
  // Entry count as the stimulus sees it, used only to steer the stimulus (operation mix, slots, episode length).
  int unsigned fill_level = 0;

  nearest_color_palette dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  nearest_color_palette_checker palette_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_results)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off when requested.
  initial begin : sink_proc
    logic hold_armed;
    hold_armed = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_req && !hold_armed) begin
        hold_armed = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
      end else if (!sink_hold_req) begin
        hold_armed = 1'b0;
      end
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Valid is only dropped when a gap is taken, so back-to-back beats keep it high.
  task automatic send_beat(input func_e op, input logic [7:0] slot,
                           input logic [14:0] red, input logic [14:0] green,
                           input logic [14:0] blue);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, blue, green, red, slot};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    if (op == FUNC_APPEND && fill_level < ENTRIES_DEF) fill_level++;
    if (op == FUNC_DELETE && slot < fill_level) fill_level--;
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  function automatic logic [14:0] random_component();
    logic [31:0] raw;
    raw = $urandom();
    case (color_mode)
      0: return raw[14:0];
      1: begin
        // A tiny value set makes repeated colors and distance ties common.
        case (raw[1:0])
          2'd0:    return 15'd0;
          2'd1:    return 15'd257;
          2'd2:    return 15'd16384;
          default: return 15'h7FFF;
        endcase
      end
      2:       return raw[0] ? 15'h7FFF : 15'h0000;
      default: return {11'd0, raw[3:0]};
    endcase
  endfunction

  task automatic send_random_op(input int unsigned target);
    int unsigned roll;
    int unsigned span;
    logic [31:0] raw;
    logic [7:0]  slot;
    func_e       op;
    roll = $urandom_range(99);
    raw  = $urandom();
    if (fill_level < target)
      op = (roll < 70) ? FUNC_APPEND : (roll < 85) ? FUNC_MAP :
           (roll < 95) ? FUNC_OVERWRITE : FUNC_DELETE;
    else
      op = (roll < 15) ? FUNC_APPEND : (roll < 55) ? FUNC_MAP :
           (roll < 75) ? FUNC_OVERWRITE : FUNC_DELETE;
    slot = raw[7:0];
    roll = $urandom_range(99);
    if (op == FUNC_DELETE && fill_level > 0 && roll < 85) begin
      slot = 8'($urandom_range(fill_level - 1));
    end else if (op == FUNC_OVERWRITE && roll < 80) begin
      span = (fill_level + 3 > 255) ? 255 : fill_level + 3;
      slot = 8'($urandom_range(span));
    end
    send_beat(op, slot, random_component(), random_component(), random_component());
  endtask

  // Runs episodes, each steering the palette toward a size and then working around it.
  task automatic run_random(input int unsigned n_items, input bit start_full);
    int unsigned sent, target, ep_len, roll;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(99);
      if (start_full) begin
        target     = ENTRIES_DEF;
        start_full = 1'b0;
      end else if (roll < 80) begin
        target = $urandom_range(24, 1);
      end else if (roll < 97) begin
        target = $urandom_range(100, 25);
      end else begin
        target = ENTRIES_DEF;
      end
      ep_len = $urandom_range(40, 10);
      if (target > fill_level) ep_len += 2 * (target - fill_level);
      color_mode = $urandom_range(3);
      while (ep_len > 0 && sent < n_items) begin
        send_random_op(target);
        sent++;
        ep_len--;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_beat(FUNC_MAP, 8'h00, 15'h0000, 15'h0000, 15'h0000);
    send_beat(FUNC_DELETE, 8'h00, 15'h7FFF, 15'h7FFF, 15'h7FFF);
    send_beat(FUNC_APPEND, 8'hFF, 15'h0000, 15'h0000, 15'h0000);
    send_beat(FUNC_APPEND, 8'h00, 15'h7FFF, 15'h7FFF, 15'h7FFF);
    send_beat(FUNC_APPEND, 8'h55, 15'h7FFF, 15'h0000, 15'h7FFF);
    send_beat(FUNC_APPEND, 8'hAA, 15'h0000, 15'h0000, 15'h0000);
    // Slots 0 and 3 are equally near; the lower index has to win.
    send_beat(FUNC_MAP, 8'h00, 15'h0000, 15'h0000, 15'h0001);
    send_beat(FUNC_MAP, 8'hFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
    send_beat(FUNC_MAP, 8'h00, 15'h4000, 15'h2000, 15'h6000);
    send_beat(FUNC_OVERWRITE, 8'hFF, 15'h2AAA, 15'h5555, 15'h1234);
    send_beat(FUNC_OVERWRITE, 8'h05, 15'h1111, 15'h2222, 15'h3333);
    send_beat(FUNC_OVERWRITE, 8'h00, 15'h0001, 15'h0002, 15'h0003);
    send_beat(FUNC_APPEND, 8'h00, 15'h3000, 15'h3000, 15'h3000);
    // This append lands on the slot written ahead of the count.
    send_beat(FUNC_APPEND, 8'h00, 15'h5000, 15'h0100, 15'h7000);
    send_beat(FUNC_MAP, 8'h00, 15'h2AAA, 15'h5555, 15'h1234);
    send_beat(FUNC_DELETE, 8'hFF, 15'h0000, 15'h0000, 15'h0000);
    send_beat(FUNC_DELETE, 8'h06, 15'h0000, 15'h0000, 15'h0000);
    send_beat(FUNC_DELETE, 8'h00, 15'h0000, 15'h0000, 15'h0000);
    send_beat(FUNC_DELETE, 8'h04, 15'h0000, 15'h0000, 15'h0000);
    send_beat(FUNC_MAP, 8'h00, 15'h7FFF, 15'h0000, 15'h7FFF);
    send_beat(FUNC_DELETE, 8'h01, 15'h0000, 15'h0000, 15'h0000);
    send_beat(FUNC_OVERWRITE, 8'h01, 15'h7FFE, 15'h0001, 15'h4321);
    send_beat(FUNC_MAP, 8'h80, 15'h7FFF, 15'h0000, 15'h4000);

    run_random(520, 1'b0);
    wait_for_results();

    src_idle_pct  <= 87;
    sink_idle_pct <= 10;
    run_random(480, 1'b0);
    wait_for_results();

    src_idle_pct  <= 0;
    sink_idle_pct <= 0;
    // Long result-side hold while beats keep coming, so the input backs up.
    sink_hold_req <= 1'b1;
    repeat (12) send_random_op(fill_level + 4);
    sink_hold_req <= 1'b0;
    run_random(680, 1'b1);
    wait_for_results();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> filelist.f
src/ncp_pkg.sv
src/nearest_color_palette.sv
sim/nearest_color_palette_checker.sv
sim/nearest_color_palette_tb.sv
